// File: rtl/core/bracket_and_operator_checker_assert.svh
// Assertion macros for the bracket and operator checker
`ifndef BRACKET_AND_OPERATOR_CHECKER_ASSERT_SVH
`define BRACKET_AND_OPERATOR_CHECKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off while arst_n is low
`define BOC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BOC_ASSERT(label, ante, cons, msg)
`define BOC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/core/boc_pkg.sv
// Types and constants shared by the bracket and operator checker
package boc_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       valid_res;
		logic [2:0] error_code;
	} out_item_t;

	typedef logic [1:0] kind_t;
	typedef logic [2:0] err_t;

	localparam kind_t KIND_ROUND  = 2'd0;
	localparam kind_t KIND_CURLY  = 2'd1;
	localparam kind_t KIND_SQUARE = 2'd2;

	localparam err_t ERR_NONE         = 3'd0;
	localparam err_t ERR_BAD_FIRST    = 3'd1;
	localparam err_t ERR_WRONG_CLOSER = 3'd2;
	localparam err_t ERR_EMPTY_POP    = 3'd3;
	localparam err_t ERR_OVERFLOW     = 3'd4;
	localparam err_t ERR_ADJ_OPS      = 3'd5;
	localparam err_t ERR_UNCLOSED     = 3'd6;

	localparam logic [7:0] CH_LROUND  = 8'h28;
	localparam logic [7:0] CH_RROUND  = 8'h29;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

endpackage

// File: rtl/core/boc_ram.sv
// Generic single-write, single-read RAM with registered read data
module boc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 63
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/bracket_and_operator_checker.sv
// Bracket and operator checker: top level
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one expression character
//   per item, with in_data.last marking the final character. Output channel
//   (out_valid/out_ready/out_data) gives one result per expression: valid_res
//   and error_code, on the item that carried last; other items give nothing.
//   A last character goes from the input register to the result register.
//   Throughput: one character per cycle, unless a last item waits on a
//   held result. The nesting stack keeps its top entry and the one below
//   it in registers and the rest in a RAM whose registered read fetches the
//   entry under the top ahead of time, so a push or pop fits in every cycle.
//   Reset: arst_n clears the stack depth, flags and error; the stack RAM needs
//   no clearing, since entries are read only after being written. The block
//   also returns to this state after every expression.
//   Stall: while out_ready is low a held result blocks only the next last
//   item; characters that are not last keep flowing, and in_ready drops only
//   when the input register holds a last item that cannot move.
`include "bracket_and_operator_checker_assert.svh"

module bracket_and_operator_checker #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  boc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output boc_pkg::out_item_t  out_data
);

	localparam int DW        = $clog2(STACK_DEPTH + 1);
	localparam int RAM_DEPTH = STACK_DEPTH - 1;
	localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	// input stage
	logic              valid_s1;
	boc_pkg::in_item_t item_s1;

	// checker state
	logic [DW-1:0]  depth_q;
	logic           prev_operator_q;
	logic           at_start_q;
	boc_pkg::err_t  first_error_q;
	boc_pkg::kind_t tos_q;
	boc_pkg::kind_t below_q;
	logic           bypass_q;

	// result register
	logic               out_valid_q;
	boc_pkg::out_item_t out_data_q;

	// stack RAM
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [AW-1:0]  ram_raddr;
	boc_pkg::kind_t ram_rdata;

	logic           s1_fire;
	logic           out_free;
	logic           is_open;
	logic           is_close;
	logic           is_op;
	boc_pkg::kind_t kind;
	boc_pkg::err_t  err_a;
	boc_pkg::err_t  err_b;
	boc_pkg::err_t  res_code;
	logic           brk_rec;
	logic           push;
	logic           pop;
	logic [DW-1:0]  depth_upd;
	logic [DW-1:0]  depth_next;
	logic [DW-1:0]  wr_full;
	logic [DW-1:0]  rd_full;
	boc_pkg::kind_t stack_below;

	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (!item_s1.last || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	// entry under the top: forwarded right after a push, else from the RAM
	assign stack_below = bypass_q ? below_q : ram_rdata;

	always_comb begin
		is_open  = 1'b0;
		is_close = 1'b0;
		is_op    = 1'b0;
		kind     = boc_pkg::KIND_ROUND;
		case (item_s1.ch) inside
			boc_pkg::CH_LROUND: begin
				is_open = 1'b1;
				kind    = boc_pkg::KIND_ROUND;
			end
			boc_pkg::CH_LCURLY: begin
				is_open = 1'b1;
				kind    = boc_pkg::KIND_CURLY;
			end
			boc_pkg::CH_LSQUARE: begin
				is_open = 1'b1;
				kind    = boc_pkg::KIND_SQUARE;
			end
			boc_pkg::CH_RROUND: begin
				is_close = 1'b1;
				kind     = boc_pkg::KIND_ROUND;
			end
			boc_pkg::CH_RCURLY: begin
				is_close = 1'b1;
				kind     = boc_pkg::KIND_CURLY;
			end
			boc_pkg::CH_RSQUARE: begin
				is_close = 1'b1;
				kind     = boc_pkg::KIND_SQUARE;
			end
			boc_pkg::CH_PLUS, boc_pkg::CH_MINUS, boc_pkg::CH_STAR, boc_pkg::CH_SLASH: begin
				is_op = 1'b1;
			end
			default: begin
				is_op = 1'b0;
			end
		endcase
	end

	always_comb begin
		err_a = first_error_q;
		if (at_start_q && (is_close || is_op) && first_error_q == boc_pkg::ERR_NONE) begin
			err_a = boc_pkg::ERR_BAD_FIRST;
		end
		brk_rec = (err_a != boc_pkg::ERR_NONE) && (err_a != boc_pkg::ERR_ADJ_OPS);
		err_b   = err_a;
		push    = 1'b0;
		pop     = 1'b0;
		if (!brk_rec) begin
			if (is_open) begin
				if (depth_q == DW'(STACK_DEPTH)) begin
					err_b = boc_pkg::ERR_OVERFLOW;
				end else begin
					push = 1'b1;
				end
			end
			if (is_close) begin
				if (depth_q == DW'(0)) begin
					err_b = boc_pkg::ERR_EMPTY_POP;
				end else begin
					pop = 1'b1;
					if (tos_q != kind) begin
						err_b = boc_pkg::ERR_WRONG_CLOSER;
					end
				end
			end
			if (is_op && prev_operator_q && err_b == boc_pkg::ERR_NONE) begin
				err_b = boc_pkg::ERR_ADJ_OPS;
			end
		end
		if (push) begin
			depth_upd = depth_q + DW'(1);
		end else if (pop) begin
			depth_upd = depth_q - DW'(1);
		end else begin
			depth_upd = depth_q;
		end
		if (err_b == boc_pkg::ERR_NONE && depth_upd != DW'(0)) begin
			res_code = boc_pkg::ERR_UNCLOSED;
		end else begin
			res_code = err_b;
		end
		if (!s1_fire) begin
			depth_next = depth_q;
		end else if (item_s1.last) begin
			depth_next = DW'(0);
		end else begin
			depth_next = depth_upd;
		end
	end

	// old top goes to RAM slot depth-1; read slot depth-2 for the next cycle
	assign wr_full   = depth_q - DW'(1);
	assign rd_full   = depth_next - DW'(2);
	assign ram_waddr = wr_full[AW-1:0];
	assign ram_raddr = rd_full[AW-1:0];
	assign ram_we    = s1_fire && !item_s1.last && push && (depth_q != DW'(0));

	boc_ram #(
		.WIDTH ($bits(boc_pkg::kind_t)),
		.DEPTH (RAM_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tos_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q         <= '0;
			prev_operator_q <= 1'b0;
			at_start_q      <= 1'b1;
			first_error_q   <= boc_pkg::ERR_NONE;
			bypass_q        <= 1'b0;
		end else if (s1_fire) begin
			if (item_s1.last) begin
				depth_q         <= '0;
				prev_operator_q <= 1'b0;
				at_start_q      <= 1'b1;
				first_error_q   <= boc_pkg::ERR_NONE;
				bypass_q        <= 1'b0;
			end else begin
				depth_q         <= depth_upd;
				prev_operator_q <= is_op;
				at_start_q      <= 1'b0;
				first_error_q   <= err_b;
				bypass_q        <= push;
			end
		end else begin
			bypass_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && push) begin
			tos_q   <= kind;
			below_q <= tos_q;
		end else if (s1_fire && pop) begin
			tos_q <= stack_below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last) begin
			out_data_q.valid_res  <= (res_code == boc_pkg::ERR_NONE);
			out_data_q.error_code <= res_code;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`BOC_ASSERT(a_valid_means_no_error, out_valid_q && out_data_q.valid_res, out_data_q.error_code == boc_pkg::ERR_NONE, "valid result carries an error code")
	`BOC_ASSERT_NEXT(a_last_restarts, s1_fire && item_s1.last, depth_q == DW'(0) && at_start_q && first_error_q == boc_pkg::ERR_NONE, "state not restarted after last item")
	`BOC_ASSERT(a_depth_bounded, 1'b1, depth_q <= DW'(STACK_DEPTH), "stack depth beyond capacity")
	`BOC_ASSERT(a_stall_only_on_last, !in_ready, valid_s1 && item_s1.last && out_valid_q && !out_ready, "input stalled without a blocked result")

endmodule
